// ===== hdl/seg_pkg.sv =====
// ----------------------------------------------------------------------------
// Segmenter package
// Shared constants, register codes and transfer types of the buffer-to-packet
// segmenter.
// ----------------------------------------------------------------------------
package seg_pkg;

	// Framing geometry.
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned INFO_BYTES   = 8;
	localparam int unsigned LENGTH_BITS  = 16;

	// Register field widths.
	localparam int unsigned MAXLEN_W = 12;
	localparam int unsigned MINLEN_W = 7;

	// Width of the per-packet overhead (header plus optional info block).
	localparam int unsigned OVH_W  = $clog2(HEADER_BYTES + INFO_BYTES + 1);
	// Width that holds a packet size and every length compare without overflow.
	localparam int unsigned WIDE_W = ((LENGTH_BITS > MAXLEN_W) ? LENGTH_BITS : MAXLEN_W) + 1;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGIC0  = 3'd0,
		REG_MAGIC1  = 3'd1,
		REG_MAGIC2  = 3'd2,
		REG_TYPE    = 3'd3,
		REG_MAX_LEN = 3'd4,
		REG_MIN_LEN = 3'd5
	} seg_reg_t;

	// Register reset values.
	localparam logic [7:0]          MAGIC0_RESET  = 8'hCA;
	localparam logic [7:0]          MAGIC1_RESET  = 8'hAE;
	localparam logic [7:0]          MAGIC2_RESET  = 8'hFE;
	localparam logic [7:0]          TYPE_RESET    = 8'h01;
	localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = MAXLEN_W'(1024);
	localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = MINLEN_W'(64);

	// Input item commands.
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} seg_cmd_t;

	// Header byte constants.
	localparam logic [7:0] FILL_BYTE        = 8'hFF;
	localparam logic [7:0] STATUS_FIRST     = 8'h02;
	localparam logic [7:0] STATUS_LAST      = 8'h01;
	localparam logic [7:0] STATUS_SIZE_MASK = 8'hFC;

	// Live configuration seen by the front and back parts.
	typedef struct packed {
		logic [7:0]          magic0;
		logic [7:0]          magic1;
		logic [7:0]          magic2;
		logic [7:0]          ptype;
		logic [MAXLEN_W-1:0] max_len;
		logic [MINLEN_W-1:0] min_len;
	} seg_cfg_t;

	// One queued job: optional header (and info block), then an optional data slot.
	typedef struct packed {
		logic       err;
		logic       hdr;
		logic       first;
		logic       empty;
		logic [7:0] status;
		logic       has_data;
		logic       data_eop;
		logic [7:0] data;
	} seg_entry_t;

endpackage

// ===== hdl/seg_if.sv =====
// ----------------------------------------------------------------------------
// Segmenter channel interfaces
// Valid/ready channels for input items, result bytes and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface seg_in_if import seg_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [LENGTH_BITS-1:0] buf_len;
	logic [7:0]             data_byte;

	modport source (output valid, output cmd, output buf_len, output data_byte,
		input ready);
	modport sink (input valid, input cmd, input buf_len, input data_byte,
		output ready);
endinterface

// Result byte channel.
interface seg_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_packet;
	logic       run_last;
	logic       protocol_error;

	modport source (output valid, output out_byte, output end_of_packet, output run_last,
		output protocol_error, input ready);
	modport sink (input valid, input out_byte, input end_of_packet, input run_last,
		input protocol_error, output ready);
endinterface

// Register write channel.
interface seg_cfg_if import seg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/seg_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front part
// Accepts input items, tracks the buffer and packet state and turns every
// item into one queued job for the back part.
// ----------------------------------------------------------------------------
module seg_front import seg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	seg_in_if.sink     item,
	input  seg_cfg_t   cfg_regs,
	output logic       push_valid,
	output seg_entry_t push_entry,
	input  logic       push_ready
);

	logic                   active_q;
	logic                   first_q;
	logic                   open_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [MAXLEN_W-1:0]    pl_q;

	logic                   active_n;
	logic                   first_n;
	logic                   open_n;
	logic [LENGTH_BITS-1:0] rem_n;
	logic [MAXLEN_W-1:0]    pl_n;

	logic                   is_start;
	logic                   op_first;
	logic [LENGTH_BITS-1:0] op_rem;
	logic [OVH_W-1:0]       op_ovh;
	logic [MAXLEN_W-1:0]    op_cap;
	logic                   op_last;
	logic [WIDE_W-1:0]      op_size;
	logic [WIDE_W-1:0]      op_pkt;
	logic [7:0]             op_size_bits;
	logic [7:0]             op_status;
	logic                   op_empty;
	logic [LENGTH_BITS-1:0] op_rem_after;

	logic                   cur_active;
	logic                   cur_open;
	logic [LENGTH_BITS-1:0] cur_rem;
	logic [MAXLEN_W-1:0]    cur_pl;
	logic [MAXLEN_W-1:0]    pl_dec;
	logic                   data_eop;

	assign is_start = (item.cmd == CMD_START);

	// Packet opening: size the packet and build its status byte.
	assign op_first = is_start ? 1'b1 : first_q;
	assign op_rem   = is_start ? item.buf_len : rem_q;
	assign op_ovh   = op_first ? OVH_W'(HEADER_BYTES + INFO_BYTES) : OVH_W'(HEADER_BYTES);

	always_comb begin
		if (cfg_regs.max_len > MAXLEN_W'(op_ovh)) begin
			op_cap = cfg_regs.max_len - MAXLEN_W'(op_ovh);
		end else begin
			op_cap = MAXLEN_W'(1);
		end
	end

	assign op_last      = WIDE_W'(op_cap) >= WIDE_W'(op_rem);
	assign op_size      = op_last ? WIDE_W'(op_rem) : WIDE_W'(op_cap);
	assign op_pkt       = op_size + WIDE_W'(op_ovh);
	assign op_size_bits = (op_pkt >= WIDE_W'(cfg_regs.min_len)) ? 8'h00 :
		({op_pkt[5:0], 2'b00} & STATUS_SIZE_MASK);
	assign op_status    = op_size_bits | (op_first ? STATUS_FIRST : 8'h00) |
		(op_last ? STATUS_LAST : 8'h00);
	assign op_empty     = (op_size == '0);
	assign op_rem_after = op_rem - op_size[LENGTH_BITS-1:0];

	// Item classification and next state.
	always_comb begin
		active_n   = active_q;
		first_n    = first_q;
		open_n     = open_q;
		rem_n      = rem_q;
		pl_n       = pl_q;
		push_entry = '0;
		cur_active = active_q;
		cur_open   = open_q;
		cur_rem    = rem_q;
		cur_pl     = pl_q;
		pl_dec     = '0;
		data_eop   = 1'b0;

		if (is_start) begin
			push_entry.hdr    = 1'b1;
			push_entry.first  = op_first;
			push_entry.empty  = op_empty;
			push_entry.status = op_status;
			active_n          = !op_empty;
			open_n            = !op_empty;
			first_n           = 1'b0;
			rem_n             = op_rem_after;
			pl_n              = op_size[MAXLEN_W-1:0];
		end else if (!active_q) begin
			// Data with no buffer: a single error byte of zero.
			push_entry.err      = 1'b1;
			push_entry.has_data = 1'b1;
		end else begin
			if (!open_q) begin
				push_entry.hdr    = 1'b1;
				push_entry.first  = op_first;
				push_entry.empty  = op_empty;
				push_entry.status = op_status;
				first_n           = 1'b0;
				cur_rem           = op_rem_after;
				cur_pl            = op_size[MAXLEN_W-1:0];
				cur_active        = !op_empty;
				cur_open          = !op_empty;
			end
			pl_dec   = (cur_pl != '0) ? (cur_pl - MAXLEN_W'(1)) : '0;
			data_eop = (pl_dec == '0);

			push_entry.has_data = 1'b1;
			push_entry.data_eop = data_eop;
			push_entry.data     = item.data_byte;

			rem_n    = cur_rem;
			pl_n     = pl_dec;
			open_n   = data_eop ? 1'b0 : cur_open;
			active_n = (data_eop && (cur_rem == '0)) ? 1'b0 : cur_active;
		end
	end

	assign push_valid = item.valid;
	assign item.ready = push_ready;

	// State update on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			open_q   <= 1'b0;
			rem_q    <= '0;
			pl_q     <= '0;
		end else if (item.valid && push_ready) begin
			active_q <= active_n;
			first_q  <= first_n;
			open_q   <= open_n;
			rem_q    <= rem_n;
			pl_q     <= pl_n;
		end
	end

endmodule

// ===== hdl/seg_fifo.sv =====
// ----------------------------------------------------------------------------
// Segmenter job queue
// Four-entry queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module seg_fifo import seg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  seg_entry_t push_entry,
	output logic       push_ready,
	output logic       head_valid,
	output seg_entry_t head_entry,
	input  logic       pop
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	seg_entry_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/seg_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter back part
// Expands each queued job into header, info and data bytes and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module seg_back import seg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  seg_cfg_t   cfg_regs,
	input  logic       head_valid,
	input  seg_entry_t head_entry,
	output logic       pop,
	seg_out_if.source  result
);

	// Byte positions within one job: header, info block, data slot.
	localparam int unsigned DATA_POS = HEADER_BYTES + INFO_BYTES;
	localparam int unsigned POS_W    = $clog2(DATA_POS + 1);

	localparam logic [POS_W-1:0] POS_MAGIC0   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC1   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_MAGIC2   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_STATUS   = POS_W'(HEADER_BYTES - 1);
	localparam logic [POS_W-1:0] POS_INFO     = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_INFO_END = POS_W'(DATA_POS - 1);
	localparam logic [POS_W-1:0] POS_DATA     = POS_W'(DATA_POS);

	logic             started_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             eop_q;
	logic             run_last_q;
	logic             err_q;

	logic             with_info;
	logic [POS_W-1:0] cur_pos;
	logic [POS_W-1:0] next_pos;
	logic [7:0]       cur_byte;
	logic             cur_eop;
	logic             cur_last;
	logic             advance;

	assign with_info = head_entry.first && (INFO_BYTES > 0);
	assign cur_pos   = started_q ? pos_q : (head_entry.hdr ? POS_MAGIC0 : POS_DATA);
	assign advance   = head_valid && (!out_valid_q || result.ready);
	assign pop       = advance && cur_last;

	// Byte selection for the current position.
	always_comb begin
		unique case (cur_pos)
			POS_MAGIC0: cur_byte = cfg_regs.magic0;
			POS_MAGIC1: cur_byte = cfg_regs.magic1;
			POS_MAGIC2: cur_byte = cfg_regs.magic2;
			POS_TYPE:   cur_byte = cfg_regs.ptype;
			POS_STATUS: cur_byte = head_entry.status;
			POS_DATA:   cur_byte = head_entry.data;
			default:    cur_byte = FILL_BYTE;
		endcase
	end

	// End-of-packet, end-of-job and next position.
	always_comb begin
		cur_eop  = 1'b0;
		cur_last = 1'b0;
		next_pos = cur_pos + POS_W'(1);
		if (cur_pos == POS_DATA) begin
			cur_eop  = head_entry.data_eop;
			cur_last = 1'b1;
		end else if (cur_pos == POS_STATUS) begin
			cur_eop  = head_entry.empty && !with_info;
			cur_last = !with_info && !head_entry.has_data;
			next_pos = with_info ? POS_INFO : POS_DATA;
		end else if (cur_pos == POS_INFO_END) begin
			cur_eop  = head_entry.empty;
			cur_last = !head_entry.has_data;
		end
	end

	// Output register; payload flops carry no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= cur_byte;
			eop_q      <= cur_eop;
			run_last_q <= cur_last;
			err_q      <= head_entry.err;
		end
	end

	// Job progress and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				started_q   <= !cur_last;
				pos_q       <= next_pos;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.out_byte       = out_byte_q;
	assign result.end_of_packet  = eop_q;
	assign result.run_last       = run_last_q;
	assign result.protocol_error = err_q;

	// An error result is always a lone, non-packet byte.
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> run_last_q && !eop_q)
		else $error("error result not marked as sole result");

	// A job in progress never runs past the data slot.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (pos_q <= POS_DATA) && head_valid)
		else $error("job position out of range or job lost");

	// A stalled result register holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(out_byte_q) && $stable(run_last_q))
		else $error("stalled result changed");

endmodule

// ===== hdl/buffer_to_packet_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// Buffer-to-packet segmenter, top level
// Cuts announced buffers into framed packets with an 8-byte header.
// ----------------------------------------------------------------------------
// Every input item is classified combinationally by the front part and queued
// as one job in a four-entry queue; the back part emits one result byte per
// cycle, unless the output stalls, into a registered output stage. A payload
// byte in an open packet yields one result byte, so data streams at one item
// per cycle when unstalled. A start item produces 16 bytes (header and info
// block), and a data item that opens a later packet produces 9 bytes; in these
// bursts the queue fills and the input stalls once it holds four jobs. The
// single-byte output port sets the sustained rate: one result byte per cycle
// unless stalled. Register writes, always accepted, apply on the next cycle.
module buffer_to_packet_segmenter_top import seg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	seg_in_if.sink    item,
	seg_out_if.source result,
	seg_cfg_if.sink   cfg
);

	seg_cfg_t   cfg_regs_q;
	logic       push_valid;
	seg_entry_t push_entry;
	logic       push_ready;
	logic       head_valid;
	seg_entry_t head_entry;
	logic       pop;

	assign cfg.ready = 1'b1;

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.magic0  <= MAGIC0_RESET;
			cfg_regs_q.magic1  <= MAGIC1_RESET;
			cfg_regs_q.magic2  <= MAGIC2_RESET;
			cfg_regs_q.ptype   <= TYPE_RESET;
			cfg_regs_q.max_len <= MAX_LEN_RESET;
			cfg_regs_q.min_len <= MIN_LEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAGIC0:  cfg_regs_q.magic0  <= cfg.data[7:0];
				REG_MAGIC1:  cfg_regs_q.magic1  <= cfg.data[7:0];
				REG_MAGIC2:  cfg_regs_q.magic2  <= cfg.data[7:0];
				REG_TYPE:    cfg_regs_q.ptype   <= cfg.data[7:0];
				REG_MAX_LEN: cfg_regs_q.max_len <= cfg.data[MAXLEN_W-1:0];
				REG_MIN_LEN: cfg_regs_q.min_len <= cfg.data[MINLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front part: classify items and queue jobs.
	seg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg_regs   (cfg_regs_q),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// Job queue between the two parts.
	seg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// Back part: expand jobs into result bytes.
	seg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs_q),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.result     (result)
	);

endmodule
